### rtl/cop_pkg.sv
// Shared constants for the circle outline point generator.
// No dependencies; every other file in this folder imports it.
`default_nettype none

package cop_pkg;

   // Field widths of the item channels and of the scale and transparency registers
   localparam int OFF_W   = 13;
   localparam int PIX_W   = 14;
   localparam int COL_W   = 8;
   localparam int SCALE_W = 3;
   localparam int TRANS_W = 7;

   // Control and status register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   typedef logic [REG_IDX_W-1:0] reg_idx_type;

   localparam reg_idx_type REG_CENTER_X     = 3'd0;
   localparam reg_idx_type REG_CENTER_Y     = 3'd1;
   localparam reg_idx_type REG_RADIUS       = 3'd2;
   localparam reg_idx_type REG_SCALE        = 3'd3;
   localparam reg_idx_type REG_BASE_RED     = 3'd4;
   localparam reg_idx_type REG_BASE_GREEN   = 3'd5;
   localparam reg_idx_type REG_BASE_BLUE    = 3'd6;
   localparam reg_idx_type REG_TRANSPARENCY = 3'd7;

   // Blend toward white in percent
   localparam logic [TRANS_W-1:0] TRANS_FULL = 7'd100;
   localparam logic [COL_W-1:0]   COL_WHITE  = 8'd255;
   localparam int                 PCT_SCALE  = 100;

   // Divide by 100 as multiply by 5243 and shift right by 19; exact below 2^15
   localparam int BLEND_NUM_W  = 15;
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int DIV100_PROD_W = 28;

endpackage

`default_nettype wire

### rtl/cop_ifs.sv
// Valid/ready channel interfaces for the circle outline point generator.
// Depends on cop_pkg for the field widths.
`default_nettype none

interface cop_req_if;
   import cop_pkg::*;

   logic             valid;
   logic             ready;
   logic [OFF_W-1:0] offset;

   modport source (output valid, output offset, input ready);
   modport sink   (input valid, input offset, output ready);
endinterface

interface cop_rsp_if;
   import cop_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [PIX_W-1:0] pixel_x;
   logic signed [PIX_W-1:0] pixel_y;
   logic [COL_W-1:0]        red;
   logic [COL_W-1:0]        green;
   logic [COL_W-1:0]        blue;
   logic                    offset_invalid;
   logic                    last;

   modport source (output valid, output pixel_x, output pixel_y, output red, output green,
                   output blue, output offset_invalid, output last, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input red, input green,
                   input blue, input offset_invalid, input last, output ready);
endinterface

`default_nettype wire

### rtl/circle_outline_point_generator.sv
// Circle outline point generator. Each offset item k on req_chan yields four outline pixels
// on rsp_chan, in the order (X+dx, Y+s), (X+dx, Y-c), (X+s, Y+dx), (X-c, Y+dx), with
// dx = k - R, s = floor(sqrt(R*R - dx*dx)) and c = s rounded up when the root is inexact;
// X, Y and R are the center and radius times the clamped scale. An offset of 2R or more
// gives a single item with offset_invalid and last set and all other fields zero. The
// radicand is formed as k*(2R-k), then a pipelined square root resolves one root bit per
// stage. An accepted offset passes the p1 and p2 registers, the square-root stages, the tl
// register and the serializer registers before its first pixel shows on rsp_chan; RW is
// COORD_BITS plus the bits of the clamped scale (13 at the defaults). The single result
// port gives four pixels per valid offset and one item per invalid offset; the pipe stalls
// and takes no offsets while its tail holds an item the serializer cannot take. Registers
// sit on an APB-style port at byte address 4*index; derived settings are registered.
// Depends on cop_pkg and the channel interfaces in cop_ifs.sv.
`default_nettype none

module circle_outline_point_generator #(
   parameter int COORD_BITS = 10,
   parameter int SCALE_MAX  = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cop_req_if.sink                            req_chan,
   cop_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [cop_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cop_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [cop_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready
);
   import cop_pkg::*;

   localparam int SC_LIM = (SCALE_MAX < 7) ? SCALE_MAX : 7;
   localparam int SC_W   = $clog2(SC_LIM + 1);
   localparam int RW     = COORD_BITS + SC_W;
   localparam int CW     = (RW + 1 > OFF_W) ? RW + 1 : OFF_W;
   localparam int EXT    = (RW + 2 > PIX_W) ? RW + 2 : PIX_W;

   // Output beat codes
   localparam logic [1:0] BEAT_UP    = 2'd0;
   localparam logic [1:0] BEAT_DOWN  = 2'd1;
   localparam logic [1:0] BEAT_RIGHT = 2'd2;
   localparam logic [1:0] BEAT_LEFT  = 2'd3;

   typedef struct packed {
      logic signed [RW:0] dx;
      logic               inv;
   } side_type;

   // ---------------------------------------------------------------- registers
   logic [COORD_BITS-1:0] center_x_ff, center_y_ff, radius_ff;
   logic [SCALE_W-1:0]    scale_ff;
   logic [COL_W-1:0]      base_red_ff, base_green_ff, base_blue_ff;
   logic [TRANS_W-1:0]    transparency_ff;
   logic                  csr_wr;
   reg_idx_type           csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[REG_IDX_W+1:2];

   // Write the addressed register, masked to its width
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         radius_ff       <= '0;
         scale_ff        <= SCALE_W'(1);
         base_red_ff     <= '0;
         base_green_ff   <= '0;
         base_blue_ff    <= '0;
         transparency_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_CENTER_X:     center_x_ff     <= csr_pwdata[COORD_BITS-1:0];
            REG_CENTER_Y:     center_y_ff     <= csr_pwdata[COORD_BITS-1:0];
            REG_RADIUS:       radius_ff       <= csr_pwdata[COORD_BITS-1:0];
            REG_SCALE:        scale_ff        <= csr_pwdata[SCALE_W-1:0];
            REG_BASE_RED:     base_red_ff     <= csr_pwdata[COL_W-1:0];
            REG_BASE_GREEN:   base_green_ff   <= csr_pwdata[COL_W-1:0];
            REG_BASE_BLUE:    base_blue_ff    <= csr_pwdata[COL_W-1:0];
            REG_TRANSPARENCY: transparency_ff <= csr_pwdata[TRANS_W-1:0];
            default:          ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (csr_idx)
         REG_CENTER_X:     csr_prdata = CSR_DATA_W'(center_x_ff);
         REG_CENTER_Y:     csr_prdata = CSR_DATA_W'(center_y_ff);
         REG_RADIUS:       csr_prdata = CSR_DATA_W'(radius_ff);
         REG_SCALE:        csr_prdata = CSR_DATA_W'(scale_ff);
         REG_BASE_RED:     csr_prdata = CSR_DATA_W'(base_red_ff);
         REG_BASE_GREEN:   csr_prdata = CSR_DATA_W'(base_green_ff);
         REG_BASE_BLUE:    csr_prdata = CSR_DATA_W'(base_blue_ff);
         REG_TRANSPARENCY: csr_prdata = CSR_DATA_W'(transparency_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- derived settings
   logic [SC_W-1:0]        sc_eff;
   logic [TRANS_W-1:0]     t_eff;
   logic [RW-1:0]          rad_in, cx_in, cy_in;
   logic [RW-1:0]          rad_ff, cx_ff, cy_ff;
   logic [BLEND_NUM_W-1:0] num_r_in, num_g_in, num_b_in;
   logic [BLEND_NUM_W-1:0] num_r_ff, num_g_ff, num_b_ff;
   logic [DIV100_PROD_W-1:0] quo_r, quo_g, quo_b;
   logic [COL_W-1:0]       col_r_ff, col_g_ff, col_b_ff;

   // Clamp scale and transparency, then scale geometry and form blend numerators
   always_comb begin
      if (scale_ff == '0)
         sc_eff = SC_W'(1);
      else if (int'(scale_ff) > SC_LIM)
         sc_eff = SC_W'(SC_LIM);
      else
         sc_eff = SC_W'(scale_ff);
      t_eff  = (transparency_ff > TRANS_FULL) ? TRANS_FULL : transparency_ff;
      rad_in = RW'(radius_ff) * RW'(sc_eff);
      cx_in  = RW'(center_x_ff) * RW'(sc_eff);
      cy_in  = RW'(center_y_ff) * RW'(sc_eff);
      // (100-t)*base + t*255 written as 100*base + t*(255-base)
      num_r_in = BLEND_NUM_W'(PCT_SCALE) * BLEND_NUM_W'(base_red_ff)
               + BLEND_NUM_W'(t_eff) * BLEND_NUM_W'(COL_WHITE - base_red_ff);
      num_g_in = BLEND_NUM_W'(PCT_SCALE) * BLEND_NUM_W'(base_green_ff)
               + BLEND_NUM_W'(t_eff) * BLEND_NUM_W'(COL_WHITE - base_green_ff);
      num_b_in = BLEND_NUM_W'(PCT_SCALE) * BLEND_NUM_W'(base_blue_ff)
               + BLEND_NUM_W'(t_eff) * BLEND_NUM_W'(COL_WHITE - base_blue_ff);
      quo_r = DIV100_PROD_W'(num_r_ff) * DIV100_PROD_W'(DIV100_MUL);
      quo_g = DIV100_PROD_W'(num_g_ff) * DIV100_PROD_W'(DIV100_MUL);
      quo_b = DIV100_PROD_W'(num_b_ff) * DIV100_PROD_W'(DIV100_MUL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rad_ff   <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         num_r_ff <= '0;
         num_g_ff <= '0;
         num_b_ff <= '0;
         col_r_ff <= '0;
         col_g_ff <= '0;
         col_b_ff <= '0;
      end else begin
         rad_ff   <= rad_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         num_r_ff <= num_r_in;
         num_g_ff <= num_g_in;
         num_b_ff <= num_b_in;
         col_r_ff <= quo_r[DIV100_SHIFT +: COL_W];
         col_g_ff <= quo_g[DIV100_SHIFT +: COL_W];
         col_b_ff <= quo_b[DIV100_SHIFT +: COL_W];
      end
   end

   // ------------------------------------------------------------------ pipeline
   logic                 adv;
   logic                 ser_free;
   logic                 tl_v_ff;
   logic                 p1_v_ff;
   logic [OFF_W-1:0]     p1_off_ff;
   logic                 p2_v_ff;
   logic [RW:0]          p2_k_ff, p2_m_ff;
   side_type             p2_side_ff;
   logic [RW:0]          p2_k_in, p2_m_in;
   side_type             p2_side_in;
   logic [2*RW+1:0]      p2_prod;

   logic                 sq_v_ff    [0:RW];
   logic [RW:0]          sq_rem_ff  [0:RW];
   logic [RW-1:0]        sq_q_ff    [0:RW];
   logic [2*RW-1:0]      sq_val_ff  [0:RW];
   side_type             sq_side_ff [0:RW];

   // Advance the whole pipe unless its tail holds an item the serializer cannot take
   assign adv            = ser_free | ~tl_v_ff;
   assign req_chan.ready = adv & ~reset;

   // Flag out-of-range offsets and form 2R-k and k-R
   always_comb begin
      p2_side_in.inv = CW'(p1_off_ff) >= CW'({rad_ff, 1'b0});
      p2_k_in        = (RW + 1)'(p1_off_ff);
      p2_m_in        = {rad_ff, 1'b0} - p2_k_in;
      p2_side_in.dx  = $signed(p2_k_in - {1'b0, rad_ff});
      p2_prod        = p2_k_ff * p2_m_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff    <= 1'b0;
         p2_v_ff    <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         p1_v_ff    <= req_chan.valid;
         p2_v_ff    <= p1_v_ff;
         sq_v_ff[0] <= p2_v_ff;
      end
      if (adv) begin
         p1_off_ff     <= req_chan.offset;
         p2_k_ff       <= p2_k_in;
         p2_m_ff       <= p2_m_in;
         p2_side_ff    <= p2_side_in;
         // R*R - dx*dx = k*(2R-k), below 2^(2*RW) for in-range offsets
         sq_val_ff[0]  <= p2_prod[2*RW-1:0];
         sq_rem_ff[0]  <= '0;
         sq_q_ff[0]    <= '0;
         sq_side_ff[0] <= p2_side_ff;
      end
   end

   // Square root: resolve one root bit per stage, most significant first
   for (genvar j = 0; j < RW; j++) begin : g_sqrt
      localparam int B = RW - 1 - j;
      logic [RW+2:0] cur, trial, diff;
      logic          ge;

      always_comb begin
         cur   = {sq_rem_ff[j], sq_val_ff[j][2*B+1 -: 2]};
         trial = {1'b0, sq_q_ff[j], 2'b01};
         diff  = cur - trial;
         ge    = cur >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset)
            sq_v_ff[j+1] <= 1'b0;
         else if (adv)
            sq_v_ff[j+1] <= sq_v_ff[j];
         if (adv) begin
            sq_rem_ff[j+1]  <= ge ? diff[RW:0] : cur[RW:0];
            sq_q_ff[j+1]    <= {sq_q_ff[j][RW-2:0], ge};
            sq_val_ff[j+1]  <= sq_val_ff[j];
            sq_side_ff[j+1] <= sq_side_ff[j];
         end
      end
   end

   // ------------------------------------------------------------ pixel geometry
   logic                    tl_inv_ff;
   logic [PIX_W-1:0]        tl_xa_ff, tl_ya_ff, tl_yp_ff, tl_ym_ff, tl_xp_ff, tl_xm_ff;
   logic [EXT-1:0]          g_x, g_y, g_dx, g_s, g_c;
   logic [EXT-1:0]          xa_in, ya_in, yp_in, ym_in, xp_in, xm_in;

   // Add root and offset to the scaled center, wrapping to the pixel width
   always_comb begin
      g_x   = EXT'(cx_ff);
      g_y   = EXT'(cy_ff);
      g_dx  = EXT'(sq_side_ff[RW].dx);
      g_s   = EXT'(sq_q_ff[RW]);
      g_c   = g_s + EXT'(sq_rem_ff[RW] != '0);
      xa_in = g_x + g_dx;
      ya_in = g_y + g_dx;
      yp_in = g_y + g_s;
      ym_in = g_y - g_c;
      xp_in = g_x + g_s;
      xm_in = g_x - g_c;
   end

   always_ff @(posedge clock) begin
      if (reset)
         tl_v_ff <= 1'b0;
      else if (adv)
         tl_v_ff <= sq_v_ff[RW];
      if (adv) begin
         tl_inv_ff <= sq_side_ff[RW].inv;
         tl_xa_ff  <= xa_in[PIX_W-1:0];
         tl_ya_ff  <= ya_in[PIX_W-1:0];
         tl_yp_ff  <= yp_in[PIX_W-1:0];
         tl_ym_ff  <= ym_in[PIX_W-1:0];
         tl_xp_ff  <= xp_in[PIX_W-1:0];
         tl_xm_ff  <= xm_in[PIX_W-1:0];
      end
   end

   // ---------------------------------------------------------- output serializer
   logic             ser_v_ff, ser_v_in;
   logic [1:0]       beat_ff, beat_in;
   logic             ser_inv_ff;
   logic [PIX_W-1:0] ser_xa_ff, ser_ya_ff, ser_yp_ff, ser_ym_ff, ser_xp_ff, ser_xm_ff;
   logic             ser_last;
   logic [PIX_W-1:0] out_x, out_y;

   assign ser_last = ser_inv_ff | (beat_ff == BEAT_LEFT);
   assign ser_free = ~ser_v_ff | (rsp_chan.ready & ser_last);

   // Load a new item when the last beat leaves, else step through the beats
   always_comb begin
      ser_v_in = ser_v_ff;
      beat_in  = beat_ff;
      if (ser_free) begin
         ser_v_in = tl_v_ff;
         beat_in  = BEAT_UP;
      end else if (rsp_chan.ready) begin
         beat_in  = beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_v_ff <= 1'b0;
         beat_ff  <= BEAT_UP;
      end else begin
         ser_v_ff <= ser_v_in;
         beat_ff  <= beat_in;
      end
      if (ser_free) begin
         ser_inv_ff <= tl_inv_ff;
         ser_xa_ff  <= tl_xa_ff;
         ser_ya_ff  <= tl_ya_ff;
         ser_yp_ff  <= tl_yp_ff;
         ser_ym_ff  <= tl_ym_ff;
         ser_xp_ff  <= tl_xp_ff;
         ser_xm_ff  <= tl_xm_ff;
      end
   end

   // Pick the pixel of the current beat
   always_comb begin
      unique case (beat_ff)
         BEAT_UP: begin
            out_x = ser_xa_ff;
            out_y = ser_yp_ff;
         end
         BEAT_DOWN: begin
            out_x = ser_xa_ff;
            out_y = ser_ym_ff;
         end
         BEAT_RIGHT: begin
            out_x = ser_xp_ff;
            out_y = ser_ya_ff;
         end
         BEAT_LEFT: begin
            out_x = ser_xm_ff;
            out_y = ser_ya_ff;
         end
         default: begin
            out_x = '0;
            out_y = '0;
         end
      endcase
   end

   // Zero everything but the flags for an out-of-range offset
   assign rsp_chan.valid          = ser_v_ff;
   assign rsp_chan.pixel_x        = ser_inv_ff ? '0 : $signed(out_x);
   assign rsp_chan.pixel_y        = ser_inv_ff ? '0 : $signed(out_y);
   assign rsp_chan.red            = ser_inv_ff ? '0 : col_r_ff;
   assign rsp_chan.green          = ser_inv_ff ? '0 : col_g_ff;
   assign rsp_chan.blue           = ser_inv_ff ? '0 : col_b_ff;
   assign rsp_chan.offset_invalid = ser_inv_ff;
   assign rsp_chan.last           = ser_last;

endmodule

`default_nettype wire

### rtl/cop_checker.sv
// Port-level checks for the circle outline point generator, attached by bind.
// Depends on cop_pkg and on the top level's channel ports.
`default_nettype none

module cop_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [cop_pkg::PIX_W-1:0]   rsp_pixel_x,
   input wire logic signed [cop_pkg::PIX_W-1:0]   rsp_pixel_y,
   input wire logic        [cop_pkg::COL_W-1:0]   rsp_red,
   input wire logic        [cop_pkg::COL_W-1:0]   rsp_green,
   input wire logic        [cop_pkg::COL_W-1:0]   rsp_blue,
   input wire logic                               rsp_offset_invalid,
   input wire logic                               rsp_last
);
   import cop_pkg::*;

   // Hold a stalled result item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
         && $stable(rsp_last) && $stable(rsp_offset_invalid))
      else $error("stalled result item changed");

   // Out-of-range offset gives one closing item with zero fields
   a_inv_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_offset_invalid |-> rsp_last && rsp_pixel_x == '0
         && rsp_pixel_y == '0 && rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)
      else $error("invalid-offset item carries data");

   // A taken non-final pixel is always followed by the next pixel of the group
   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && !rsp_offset_invalid)
      else $error("pixel group broken");

   // Drop any result during reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown after reset");

endmodule

bind circle_outline_point_generator cop_checker u_cop_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_pixel_x        (rsp_chan.pixel_x),
   .rsp_pixel_y        (rsp_chan.pixel_y),
   .rsp_red            (rsp_chan.red),
   .rsp_green          (rsp_chan.green),
   .rsp_blue           (rsp_chan.blue),
   .rsp_offset_invalid (rsp_chan.offset_invalid),
   .rsp_last           (rsp_chan.last)
);

`default_nettype wire

### bench/tb.sv
// Testbench for circle_outline_point_generator: directed table, then random sweeps.
// Checks every pixel item against an in-bench outline predictor; needs cop_pkg,
// cop_ifs.sv and the generator RTL.
`timescale 1ns / 1ps

module tb;
   import cop_pkg::*;

   localparam int COORD_LIMIT    = 10;
   localparam int SCALE_LIMIT    = 4;
   localparam int DRAIN_CYCLES   = 40;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 30;

   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      logic [COL_W-1:0] red;
      logic [COL_W-1:0] green;
      logic [COL_W-1:0] blue;
      logic             invalid;
      logic             last;
   } pixel_type;

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      reg_idx_type      idx;
      logic [31:0]      value;
      logic [OFF_W-1:0] offset;
      bit               typed;
      pixel_type        want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   cop_req_if req_if ();
   cop_rsp_if rsp_if ();

   // Shadow copy of the configuration registers
   logic [COORD_LIMIT-1:0] cx_reg, cy_reg, radius_reg;
   logic [SCALE_W-1:0]     scale_reg;
   logic [COL_W-1:0]       red_reg, green_reg, blue_reg;
   logic [TRANS_W-1:0]     trans_reg;

   pixel_type    pending_pixels[$];
   stim_row_type directed_rows[$];

   logic      item_typed;
   pixel_type typed_want;
   bit        calm;
   bit        cfg_dirty;
   int        hold_off_asked;
   int        quiet_cycles;
   int        error_count;

   circle_outline_point_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic pixel_type make_pixel(input longint x, input longint y,
                                            input logic [COL_W-1:0] r,
                                            input logic [COL_W-1:0] g,
                                            input logic [COL_W-1:0] b, input logic inv,
                                            input logic lst);
      pixel_type p;
      p.px      = x[PIX_W-1:0];
      p.py      = y[PIX_W-1:0];
      p.red     = r;
      p.green   = g;
      p.blue    = b;
      p.invalid = inv;
      p.last    = lst;
      return p;
   endfunction

   function automatic longint floor_root(input longint v);
      longint root;
      longint trial;
      root = 0;
      for (int b = 13; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   function automatic logic [COL_W-1:0] blend_to_white(input logic [COL_W-1:0] base,
                                                       input int t);
      int sum;
      sum = (PCT_SCALE - t) * int'(base) + t * int'(COL_WHITE);
      return COL_W'(sum / PCT_SCALE);
   endfunction

   function automatic longint eff_scale();
      if (scale_reg == 0) return 1;
      if (scale_reg > SCALE_LIMIT) return SCALE_LIMIT;
      return scale_reg;
   endfunction

   // Queue the outline pixels for one sweep offset
   function automatic void predict_outline(input logic [OFF_W-1:0] k);
      longint sc, big_r, cen_x, cen_y, kk, dx, rad_sq, s, c;
      int t;
      logic [COL_W-1:0] r, g, b;
      sc    = eff_scale();
      big_r = longint'(radius_reg) * sc;
      cen_x = longint'(cx_reg) * sc;
      cen_y = longint'(cy_reg) * sc;
      kk    = longint'(k);
      if (kk >= 2 * big_r) begin
         pending_pixels.push_back(make_pixel(0, 0, 0, 0, 0, 1'b1, 1'b1));
         return;
      end
      t = (trans_reg > TRANS_FULL) ? int'(TRANS_FULL) : int'(trans_reg);
      r = blend_to_white(red_reg, t);
      g = blend_to_white(green_reg, t);
      b = blend_to_white(blue_reg, t);
      dx     = kk - big_r;
      rad_sq = big_r * big_r - dx * dx;
      s      = floor_root(rad_sq);
      c      = (s * s == rad_sq) ? s : s + 1;
      pending_pixels.push_back(make_pixel(cen_x + dx, cen_y + s, r, g, b, 1'b0, 1'b0));
      pending_pixels.push_back(make_pixel(cen_x + dx, cen_y - c, r, g, b, 1'b0, 1'b0));
      pending_pixels.push_back(make_pixel(cen_x + s, cen_y + dx, r, g, b, 1'b0, 1'b0));
      pending_pixels.push_back(make_pixel(cen_x - c, cen_y + dx, r, g, b, 1'b0, 1'b1));
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   // Track both channels: queue predictions on input, compare on output
   always @(posedge clock) begin
      pixel_type want;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_if.valid && rsp_if.ready) begin
            quiet_cycles = 0;
            if (pending_pixels.size() == 0) begin
               error_count++;
               $display("%0t: pixel item with none expected, got x=0x%0h y=0x%0h", $time,
                        rsp_if.pixel_x, rsp_if.pixel_y);
            end else begin
               want = pending_pixels.pop_front();
               check_field("pixel_x", want.px, rsp_if.pixel_x[PIX_W-1:0]);
               check_field("pixel_y", want.py, rsp_if.pixel_y[PIX_W-1:0]);
               check_field("red", want.red, rsp_if.red);
               check_field("green", want.green, rsp_if.green);
               check_field("blue", want.blue, rsp_if.blue);
               check_field("offset_invalid", want.invalid, rsp_if.offset_invalid);
               check_field("last", want.last, rsp_if.last);
            end
         end
         if (req_if.valid && req_if.ready) begin
            quiet_cycles = 0;
            if (item_typed) pending_pixels.push_back(typed_want);
            else predict_outline(req_if.offset);
         end
      end
   end

   // End the run when nothing moves for too long
   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: random stalls, a calm stretch, and one long hold-off on request
   initial begin : sink_side
      int served;
      served = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_asked > served) begin
            served++;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
      end
   end

   // Drop valid and wait until every expected pixel has arrived
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register while the block is idle, and mirror it in the shadow copy
   task automatic program_reg(input reg_idx_type idx, input logic [31:0] value);
      if (!cfg_dirty) wait_idle();
      cfg_dirty = 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_CENTER_X:     cx_reg     = value[COORD_LIMIT-1:0];
         REG_CENTER_Y:     cy_reg     = value[COORD_LIMIT-1:0];
         REG_RADIUS:       radius_reg = value[COORD_LIMIT-1:0];
         REG_SCALE:        scale_reg  = value[SCALE_W-1:0];
         REG_BASE_RED:     red_reg    = value[COL_W-1:0];
         REG_BASE_GREEN:   green_reg  = value[COL_W-1:0];
         REG_BASE_BLUE:    blue_reg   = value[COL_W-1:0];
         REG_TRANSPARENCY: trans_reg  = value[TRANS_W-1:0];
         default: ;
      endcase
   endtask

   // Offer one offset item, with random gaps ahead of it, and hold until accepted
   task automatic send_offset(input logic [OFF_W-1:0] k, input bit typed,
                              input pixel_type want);
      if (cfg_dirty) begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         cfg_dirty = 1'b0;
      end
      while (!calm && $urandom_range(99) < 13) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.offset <= k;
      item_typed    <= typed;
      typed_want    <= want;
      do @(posedge clock); while (!req_if.ready);
   endtask

   function automatic void add_write(input reg_idx_type idx, input logic [31:0] value);
      stim_row_type row;
      row.kind  = ROW_WRITE;
      row.idx   = idx;
      row.value = value;
      row.offset = '0;
      row.typed = 1'b0;
      row.want  = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_item(input logic [OFF_W-1:0] k, input bit typed,
                                    input pixel_type want);
      stim_row_type row;
      row.kind   = ROW_ITEM;
      row.idx    = REG_CENTER_X;
      row.value  = '0;
      row.offset = k;
      row.typed  = typed;
      row.want   = want;
      directed_rows.push_back(row);
   endfunction

   // Mostly in-sweep offsets; the rest at the boundary or anywhere
   function automatic logic [OFF_W-1:0] pick_offset();
      longint two_r;
      int roll;
      two_r = 2 * longint'(radius_reg) * eff_scale();
      roll  = $urandom_range(99);
      if (two_r == 0 || roll < 8) return OFF_W'($urandom_range(8191));
      if (roll < 15) return OFF_W'(two_r + $urandom_range(3));
      return OFF_W'($urandom_range(int'(two_r) - 1));
   endfunction

   // Pick register values for one random phase
   task automatic setup_phase(input int ph);
      case (ph)
         1: begin
            // largest circle, full blend to white
            program_reg(REG_CENTER_X, 1023);
            program_reg(REG_CENTER_Y, 1023);
            program_reg(REG_RADIUS, 1023);
            program_reg(REG_SCALE, SCALE_LIMIT);
            program_reg(REG_BASE_RED, 255);
            program_reg(REG_BASE_GREEN, 255);
            program_reg(REG_BASE_BLUE, 255);
            program_reg(REG_TRANSPARENCY, TRANS_FULL);
         end
         2: begin
            // smallest circle at the origin, opaque black
            program_reg(REG_CENTER_X, 0);
            program_reg(REG_CENTER_Y, 0);
            program_reg(REG_RADIUS, 1);
            program_reg(REG_SCALE, 1);
            program_reg(REG_BASE_RED, 0);
            program_reg(REG_BASE_GREEN, 0);
            program_reg(REG_BASE_BLUE, 0);
            program_reg(REG_TRANSPARENCY, 0);
         end
         3: begin
            // raw words, unused bits included
            program_reg(REG_CENTER_X, $urandom());
            program_reg(REG_CENTER_Y, $urandom());
            program_reg(REG_RADIUS, $urandom());
            program_reg(REG_SCALE, $urandom());
            program_reg(REG_BASE_RED, $urandom());
            program_reg(REG_BASE_GREEN, $urandom());
            program_reg(REG_BASE_BLUE, $urandom());
            program_reg(REG_TRANSPARENCY, $urandom());
         end
         default: begin
            program_reg(REG_CENTER_X, $urandom_range(1023));
            program_reg(REG_CENTER_Y, $urandom_range(1023));
            program_reg(REG_RADIUS, (ph == 5) ? $urandom_range(1023) : $urandom_range(40, 1));
            program_reg(REG_SCALE, (ph == 7) ? $urandom_range(7, 5) : $urandom_range(4, 1));
            program_reg(REG_BASE_RED, $urandom_range(255));
            program_reg(REG_BASE_GREEN, $urandom_range(255));
            program_reg(REG_BASE_BLUE, $urandom_range(255));
            program_reg(REG_TRANSPARENCY,
                        (ph == 7) ? $urandom_range(127, 101) : $urandom_range(100));
         end
      endcase
   endtask

   initial begin : stimulus
      pixel_type bad;
      pixel_type blank;
      bad   = make_pixel(0, 0, 0, 0, 0, 1'b1, 1'b1);
      blank = '0;

      // Hold every input at a known value and mirror the reset register state
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.offset  <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      item_typed     <= 1'b0;
      typed_want     <= '0;
      calm           = 1'b0;
      cfg_dirty      = 1'b0;
      hold_off_asked = 0;
      quiet_cycles   = 0;
      error_count    = 0;
      cx_reg = '0; cy_reg = '0; radius_reg = '0; scale_reg = 1;
      red_reg = '0; green_reg = '0; blue_reg = '0; trans_reg = '0;

      // Zero radius after reset: every offset is out of the sweep
      add_item(0, 1'b1, bad);
      add_item(8191, 1'b1, bad);
      // Small circle, half blend; sweep ends, center, first offset past the end
      add_write(REG_CENTER_X, 10);
      add_write(REG_CENTER_Y, 20);
      add_write(REG_RADIUS, 5);
      add_write(REG_SCALE, 1);
      add_write(REG_BASE_RED, 200);
      add_write(REG_BASE_GREEN, 100);
      add_write(REG_BASE_BLUE, 0);
      add_write(REG_TRANSPARENCY, 50);
      add_item(0, 1'b0, blank);
      add_item(5, 1'b0, blank);
      add_item(3, 1'b0, blank);
      add_item(9, 1'b0, blank);
      add_item(10, 1'b1, bad);
      add_item(8191, 1'b1, bad);
      // Scale of zero acts as one, transparency above full acts as white
      add_write(REG_RADIUS, 3);
      add_write(REG_SCALE, 0);
      add_write(REG_TRANSPARENCY, 127);
      add_item(0, 1'b0, blank);
      add_item(2, 1'b0, blank);
      add_item(5, 1'b0, blank);
      add_item(6, 1'b1, bad);
      // Scale above the limit clamps; unused radius bits drop; far corner
      add_write(REG_SCALE, 7);
      add_write(REG_RADIUS, 32'hFFFF_FFFF);
      add_write(REG_CENTER_X, 1023);
      add_write(REG_CENTER_Y, 1023);
      add_write(REG_TRANSPARENCY, 0);
      add_write(REG_BASE_RED, 255);
      add_write(REG_BASE_GREEN, 255);
      add_write(REG_BASE_BLUE, 255);
      add_item(0, 1'b0, blank);
      add_item(4092, 1'b0, blank);
      add_item(4095, 1'b0, blank);
      add_item(4096, 1'b0, blank);
      add_item(8183, 1'b0, blank);
      add_item(8184, 1'b1, bad);
      // Unit circle at the origin: negative coordinates
      add_write(REG_CENTER_X, 0);
      add_write(REG_CENTER_Y, 0);
      add_write(REG_RADIUS, 1);
      add_write(REG_SCALE, 1);
      add_item(0, 1'b0, blank);
      add_item(1, 1'b0, blank);
      add_item(2, 1'b1, bad);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE)
            program_reg(directed_rows[i].idx, directed_rows[i].value);
         else
            send_offset(directed_rows[i].offset, directed_rows[i].typed, directed_rows[i].want);
      end

      // Random phases, each with its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         setup_phase(ph);
         calm = (ph == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 0 && n == 5) hold_off_asked++;
            if (ph == 5 && n == 16) wait_idle();
            send_offset(pick_offset(), 1'b0, blank);
         end
         calm = 1'b0;
      end

      wait_idle();
      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/cop_pkg.sv
rtl/cop_ifs.sv
rtl/circle_outline_point_generator.sv
rtl/cop_checker.sv
bench/tb.sv
